@@ sv/scm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the sample constraint monitor: check kind
// codes, register indexes, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package scm_pkg;

	// Fixed field widths.
	localparam int SAMPLE_W = 32;
	localparam int TIME_W   = 64;
	localparam int LIMIT_W  = 48;
	localparam int KIND_W   = 3;
	localparam int LEN_W    = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;

	// Default window depth.
	localparam int WINDOW_MAX_DEF = 64;

	// Check kinds.
	localparam logic [KIND_W-1:0] KIND_MIN     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_MAX     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SUM_MAX = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INT_MIN = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INT_MAX = 3'd4;
	localparam logic [KIND_W-1:0] KIND_AVG_MIN = 3'd5;
	localparam logic [KIND_W-1:0] KIND_AVG_MAX = 3'd6;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_KIND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALT       = 2'd3;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_WIN,
		ST_DIV,
		ST_EVAL
	} scm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic win;
		logic div_step;
		logic commit;
	} scm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_avg;
		logic win_full;
		logic div_last;
		logic out_busy;
	} scm_status_t;

endpackage
`default_nettype wire

@@ sv/scm_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scm_ctrl
// Sequencer of the monitor: takes one input beat, prepares it, in average
// modes updates the window and divides when full, and commits the result.
// ----------------------------------------------------------------------------
module scm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  scm_pkg::scm_status_t status,
	output scm_pkg::scm_cmd_t    cmd
);
	import scm_pkg::*;

	scm_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = status.is_avg ? ST_WIN : ST_EVAL;
			end
			ST_WIN: begin
				cmd.win = 1'b1;
				state_d = status.win_full ? ST_DIV : ST_EVAL;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				// Wait until the output register is free.
				if (!status.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/scm_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scm_dp
// Datapath of the monitor: configuration registers, running sum, interval
// timer, sample window memory with its running total, serial divider for the
// average, limit compare, violation status and the output register.
// ----------------------------------------------------------------------------
module scm_dp #(
	parameter int WINDOW_MAX = scm_pkg::WINDOW_MAX_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_write,
	input  wire [scm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [scm_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire signed [scm_pkg::SAMPLE_W-1:0]   sample,
	input  wire [scm_pkg::TIME_W-1:0]            timestamp,
	input  scm_pkg::scm_cmd_t                    cmd,
	output scm_pkg::scm_status_t                 status,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 evaluated,
	output logic                                 violation_started,
	output logic                                 violation_ended,
	output logic [scm_pkg::TIME_W-1:0]           interval_begin,
	output logic [scm_pkg::TIME_W-1:0]           interval_finish,
	output logic                                 in_violation,
	output logic                                 halt,
	output logic                                 ever_violated
);
	import scm_pkg::*;

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int TW = SAMPLE_W + $clog2(WINDOW_MAX);
	localparam int LW_MAX = $clog2(WINDOW_MAX + 1);
	localparam int CW = (LW_MAX > LEN_W) ? LW_MAX : LEN_W;
	localparam int CNT_W = $clog2(TW);

	localparam logic signed [LIMIT_W:0] SUM_HI = {2'b00, {(LIMIT_W-1){1'b1}}};
	localparam logic signed [LIMIT_W:0] SUM_LO = {2'b11, {(LIMIT_W-1){1'b0}}};
	localparam logic signed [TIME_W-1:0] WORK_HI = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] WORK_LO = {1'b1, {(TIME_W-2){1'b0}}, 1'b1};

	// Configuration registers.
	logic [KIND_W-1:0]         kind_q;
	logic signed [LIMIT_W-1:0] limit_q;
	logic [LEN_W-1:0]          wlen_q;
	logic                      halt_en_q;

	// Item state.
	logic signed [LIMIT_W-1:0] running_q;
	logic [TIME_W-1:0]         prev_q;
	logic [TIME_W-1:0]         open_q;
	logic                      violated_q;
	logic signed [TW-1:0]      total_q;
	logic [IW-1:0]             widx_q;
	logic [LEN_W-1:0]          fill_q;

	// Per-item working registers.
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [TIME_W-1:0]          time_q;
	logic signed [TIME_W-1:0]   work_q;
	logic                       eval_q;
	logic [IW-1:0]              idx_q;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic [TW-1:0]              quo_q;
	logic [LEN_W-1:0]           rem_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           cnt_q;

	// Window memory.
	logic signed [SAMPLE_W-1:0] window_mem [WINDOW_MAX];

	// Output register.
	logic              out_valid_q;
	logic              evaluated_q;
	logic              started_q;
	logic              ended_q;
	logic [TIME_W-1:0] begin_q;
	logic [TIME_W-1:0] finish_q;
	logic              in_viol_q;
	logic              halt_q;
	logic              ever_q;

	// Effective window length, clamped to the supported range.
	logic [CW-1:0]    wlen_ext;
	logic [CW-1:0]    len_c;
	logic [LEN_W-1:0] len;
	always_comb begin
		wlen_ext = CW'(wlen_q);
		if (wlen_ext < CW'(2)) begin
			len_c = CW'(2);
		end else if (wlen_ext > CW'(WINDOW_MAX)) begin
			len_c = CW'(WINDOW_MAX);
		end else begin
			len_c = wlen_ext;
		end
		len = len_c[LEN_W-1:0];
	end

	// Window slot for this sample, and the slot after it.
	logic [IW-1:0] idx_c;
	logic [CW-1:0] idx_inc;
	logic [IW-1:0] idx_next;
	always_comb begin
		idx_c   = (CW'(widx_q) >= len_c) ? '0 : widx_q;
		idx_inc = CW'(idx_q) + CW'(1);
		idx_next = (idx_inc >= len_c) ? '0 : idx_inc[IW-1:0];
	end

	// Saturating running sum.
	logic signed [LIMIT_W:0]   sum_wide;
	logic signed [LIMIT_W-1:0] sum_c;
	always_comb begin
		sum_wide = {running_q[LIMIT_W-1], running_q}
			+ (LIMIT_W+1)'(sample_q);
		if (sum_wide > SUM_HI) begin
			sum_c = SUM_HI[LIMIT_W-1:0];
		end else if (sum_wide < SUM_LO) begin
			sum_c = SUM_LO[LIMIT_W-1:0];
		end else begin
			sum_c = sum_wide[LIMIT_W-1:0];
		end
	end

	// Signed, saturated distance to the previous timestamp.
	logic [TIME_W-1:0]        fwd_c;
	logic [TIME_W-1:0]        back_c;
	logic signed [TIME_W-1:0] gap_c;
	always_comb begin
		fwd_c  = time_q - prev_q;
		back_c = prev_q - time_q;
		if (time_q >= prev_q) begin
			gap_c = fwd_c[TIME_W-1] ? WORK_HI : $signed(fwd_c);
		end else begin
			gap_c = back_c[TIME_W-1] ? WORK_LO : -$signed(back_c);
		end
	end

	// Window total after replacing the oldest sample.
	logic                 full_before;
	logic [LEN_W-1:0]     fill_next;
	logic signed [TW-1:0] drop_c;
	logic signed [TW-1:0] total_next;
	logic [TW-1:0]        mag_c;
	always_comb begin
		full_before = fill_q >= len;
		fill_next   = full_before ? fill_q : fill_q + LEN_W'(1);
		drop_c      = full_before ? TW'(rd_q) : '0;
		total_next  = total_q - drop_c + TW'(sample_q);
		mag_c       = total_next[TW-1] ? TW'(-total_next) : TW'(total_next);
	end

	// One restoring divide step.
	logic [LEN_W:0]           trial;
	logic                     qbit;
	logic [LEN_W-1:0]         rem_next;
	logic [TW-1:0]            quo_next;
	logic signed [TIME_W-1:0] quo_ext;
	logic signed [TIME_W-1:0] avg_c;
	always_comb begin
		trial    = {rem_q, quo_q[TW-1]};
		qbit     = trial >= {1'b0, len};
		rem_next = qbit ? LEN_W'(trial - {1'b0, len}) : trial[LEN_W-1:0];
		quo_next = {quo_q[TW-2:0], qbit};
		quo_ext  = $signed({{(TIME_W-TW){1'b0}}, quo_next});
		avg_c    = neg_q ? -quo_ext : quo_ext;
	end

	// Limit compare and violation status update.
	logic                     is_min;
	logic signed [TIME_W-1:0] limit_ext;
	logic                     below;
	logic                     above;
	logic                     started_c;
	logic                     ended_c;
	always_comb begin
		is_min = (kind_q == KIND_MIN) || (kind_q == KIND_INT_MIN)
			|| (kind_q == KIND_AVG_MIN);
		limit_ext = TIME_W'(limit_q);
		below = work_q < limit_ext;
		above = work_q > limit_ext;
		started_c = 1'b0;
		ended_c   = 1'b0;
		if (eval_q) begin
			if (open_q == '0) begin
				started_c = is_min ? below : above;
			end else begin
				ended_c = is_min ? above : below;
			end
		end
	end

	// Control and status registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= KIND_MIN;
			limit_q     <= '0;
			wlen_q      <= LEN_W'(2);
			halt_en_q   <= 1'b0;
			running_q   <= '0;
			prev_q      <= '0;
			open_q      <= '0;
			violated_q  <= 1'b0;
			total_q     <= '0;
			widx_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_CHECK_KIND: kind_q <= cfg_data[KIND_W-1:0];
					REG_LIMIT:      limit_q <= cfg_data[LIMIT_W-1:0];
					REG_WINDOW_LEN: begin
						wlen_q  <= cfg_data[LEN_W-1:0];
						total_q <= '0;
						widx_q  <= '0;
						fill_q  <= '0;
					end
					REG_HALT:       halt_en_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.prep) begin
				if (kind_q == KIND_SUM_MAX) begin
					running_q <= sum_c;
				end
				if ((kind_q == KIND_INT_MIN) || (kind_q == KIND_INT_MAX)) begin
					prev_q <= time_q;
				end
			end
			if (cmd.win) begin
				total_q <= total_next;
				fill_q  <= fill_next;
				widx_q  <= idx_next;
			end
			if (cmd.commit) begin
				if (started_c) begin
					violated_q <= 1'b1;
					open_q     <= time_q;
				end else if (ended_c) begin
					open_q <= '0;
				end
			end
			// The output register is loaded by commit and emptied by a taken beat.
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers, divider and output payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
			time_q   <= timestamp;
		end
		if (cmd.prep) begin
			idx_q  <= idx_c;
			unique case (kind_q)
				KIND_MIN, KIND_MAX: begin
					work_q <= TIME_W'(sample_q);
					eval_q <= 1'b1;
				end
				KIND_SUM_MAX: begin
					work_q <= TIME_W'(sum_c);
					eval_q <= 1'b1;
				end
				KIND_INT_MIN, KIND_INT_MAX: begin
					work_q <= gap_c;
					eval_q <= prev_q != '0;
				end
				default: begin
					eval_q <= 1'b0;
				end
			endcase
		end
		if (cmd.win) begin
			quo_q <= mag_c;
			rem_q <= '0;
			neg_q <= total_next[TW-1];
			cnt_q <= CNT_W'(TW - 1);
			eval_q <= 1'b0;
		end
		if (cmd.div_step) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				work_q <= avg_c;
				eval_q <= 1'b1;
			end
		end
		if (cmd.commit) begin
			evaluated_q <= eval_q;
			started_q   <= started_c;
			ended_q     <= ended_c;
			begin_q     <= started_c ? time_q : open_q;
			finish_q    <= time_q;
			in_viol_q   <= started_c ? (time_q != '0) : (!ended_c && (open_q != '0));
			halt_q      <= started_c && halt_en_q;
			ever_q      <= violated_q || started_c;
		end
	end

	// Window memory with registered read.
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rd_q <= window_mem[idx_c];
		end
		if (cmd.win) begin
			window_mem[idx_q] <= sample_q;
		end
	end

	// Status to the controller.
	always_comb begin
		status.is_avg   = (kind_q == KIND_AVG_MIN) || (kind_q == KIND_AVG_MAX);
		status.win_full = fill_next >= len;
		status.div_last = cnt_q == '0;
		status.out_busy = out_valid_q && !out_ready;
	end

	assign out_valid         = out_valid_q;
	assign evaluated         = evaluated_q;
	assign violation_started = started_q;
	assign violation_ended   = ended_q;
	assign interval_begin    = begin_q;
	assign interval_finish   = finish_q;
	assign in_violation      = in_viol_q;
	assign halt              = halt_q;
	assign ever_violated     = ever_q;

endmodule
`default_nettype wire

@@ sv/sample_constraint_monitor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sample_constraint_monitor
// Checks a stream of timestamped samples against one limit and reports the
// opening and closing of violation intervals, one result beat per sample.
//
//   Channel  Direction  Handshake             Payload
//   cfg      in         cfg_write             cfg_index, cfg_data
//   in       in         in_valid / in_ready   sample, timestamp
//   out      out        out_valid / out_ready evaluated .. ever_violated
//
// A sample passes through the load, preparation and commit steps in the value,
// sum and interval modes. In the average modes it also passes through the
// window update step and, once the window is full, through the serial
// restoring divider, one quotient bit per cycle.
// The result sits in an output register; the next sample is taken while it
// waits, and the block stalls before its commit step until that register
// is free. Reset needs no clearing pass; the window memory is not reset.
// ----------------------------------------------------------------------------
module sample_constraint_monitor #(
	parameter int WINDOW_MAX = scm_pkg::WINDOW_MAX_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_write,
	input  wire [scm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [scm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire signed [scm_pkg::SAMPLE_W-1:0] sample,
	input  wire [scm_pkg::TIME_W-1:0]          timestamp,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic                               evaluated,
	output logic                               violation_started,
	output logic                               violation_ended,
	output logic [scm_pkg::TIME_W-1:0]         interval_begin,
	output logic [scm_pkg::TIME_W-1:0]         interval_finish,
	output logic                               in_violation,
	output logic                               halt,
	output logic                               ever_violated
);
	import scm_pkg::*;

	scm_cmd_t    cmd;
	scm_status_t status;

	// Sequencer.
	scm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	scm_dp #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.sample            (sample),
		.timestamp         (timestamp),
		.cmd               (cmd),
		.status            (status),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.evaluated         (evaluated),
		.violation_started (violation_started),
		.violation_ended   (violation_ended),
		.interval_begin    (interval_begin),
		.interval_finish   (interval_finish),
		.in_violation      (in_violation),
		.halt              (halt),
		.ever_violated     (ever_violated)
	);

endmodule
`default_nettype wire

@@ sv/scm_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scm_checker
// Port-level checks of the monitor's result beats, bound to the top level.
// ----------------------------------------------------------------------------
module scm_checker (
	input wire                       clk,
	input wire                       arst_n,
	input wire                       out_valid,
	input wire                       out_ready,
	input wire                       evaluated,
	input wire                       violation_started,
	input wire                       violation_ended,
	input wire [scm_pkg::TIME_W-1:0] interval_finish,
	input wire                       in_violation,
	input wire                       halt,
	input wire                       ever_violated
);
	import scm_pkg::*;

	// Remembers that a delivered beat reported a violation.
	logic seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (out_valid && out_ready && ever_violated) begin
			seen_q <= 1'b1;
		end
	end

	// An interval opens or closes only on a compared sample.
	a_change_needs_eval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (violation_started || violation_ended) |-> evaluated)
		else $error("interval change without a compare");

	// A closing beat leaves no interval open and opens none.
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && violation_ended |-> !in_violation && !violation_started)
		else $error("closed interval still open");

	// Halt only comes with a violation start.
	a_halt_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && halt |-> violation_started && ever_violated)
		else $error("halt without a violation start");

	// The violation flag is sticky across beats.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |-> ever_violated)
		else $error("sticky violation flag dropped");

	// A stalled result beat holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(interval_finish))
		else $error("stalled result beat changed");

endmodule

bind sample_constraint_monitor scm_checker u_scm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.evaluated         (evaluated),
	.violation_started (violation_started),
	.violation_ended   (violation_ended),
	.interval_finish   (interval_finish),
	.in_violation      (in_violation),
	.halt              (halt),
	.ever_violated     (ever_violated)
);
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sample_constraint_monitor. Samples are driven
// through the valid/ready input channel and every result beat is compared,
// field by field, with a cycle-free model of the monitor kept in this file.
// Directed checks cover the limit crossings, interval saturation, window
// truncation and the unused kind. Randomized segments under changing
// configurations and back-pressure follow, and a final run swings the running
// sum hard in both directions with extreme samples.
// ----------------------------------------------------------------------------
module testbench;
	import scm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int WINDOW_DEPTH = WINDOW_MAX_DEF;
	localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint TICK_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint WORD_HI = 64'sd2147483647;
	localparam longint WORD_LO = -WORD_HI - 1;
	localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = 32'h7FFF_FFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_BOTTOM = 32'h8000_0000;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	// Expected contents of one result beat.
	typedef struct {
		logic evaluated;
		logic started;
		logic ended;
		logic [TIME_W-1:0] begin_ts;
		logic [TIME_W-1:0] finish_ts;
		logic in_viol;
		logic halted;
		logic ever;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [TIME_W-1:0] timestamp;
	logic out_valid;
	logic out_ready;
	logic evaluated;
	logic violation_started;
	logic violation_ended;
	logic [TIME_W-1:0] interval_begin;
	logic [TIME_W-1:0] interval_finish;
	logic in_violation;
	logic halt;
	logic ever_violated;

	// Configuration as the monitor should hold it.
	logic [KIND_W-1:0] kind_cfg = KIND_MIN;
	longint limit_cfg = 0;
	logic [LEN_W-1:0] wlen_cfg = 7'd2;
	logic halt_cfg = 1'b0;

	// Monitor state mirrored by the model.
	longint sum_acc = 0;
	int win_vals [WINDOW_DEPTH];
	longint win_sum = 0;
	int unsigned win_pos = 0;
	int unsigned win_count = 0;
	logic [TIME_W-1:0] last_ts = '0;
	logic [TIME_W-1:0] open_since = '0;
	logic any_violation = 1'b0;

	verdict_t pending_verdicts [$];
	verdict_t oldest;
	int error_count = 0;
	int unsigned cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic [TIME_W-1:0] ts_cursor = '0;

	sample_constraint_monitor uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.timestamp(timestamp),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.evaluated(evaluated),
		.violation_started(violation_started),
		.violation_ended(violation_ended),
		.interval_begin(interval_begin),
		.interval_finish(interval_finish),
		.in_violation(in_violation),
		.halt(halt),
		.ever_violated(ever_violated)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run time guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// Output back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Effective averaging window; out-of-range lengths are clamped.
	function automatic int unsigned window_span();
		if (wlen_cfg < 2)
			return 2;
		if (wlen_cfg > WINDOW_DEPTH)
			return WINDOW_DEPTH;
		return wlen_cfg;
	endfunction

	// Advances the mirrored state by one sample and returns the result beat.
	function automatic verdict_t judge_sample(input int s, input logic [TIME_W-1:0] t);
		verdict_t v;
		longint work;
		longint total;
		logic [TIME_W-1:0] gap;
		int unsigned span;
		int unsigned slot;
		bit eval_now;
		bit is_min;
		work = 0;
		eval_now = 1'b0;
		is_min = 1'b0;
		case (kind_cfg)
		KIND_MIN: begin
			work = s;
			eval_now = 1'b1;
			is_min = 1'b1;
		end
		KIND_MAX: begin
			work = s;
			eval_now = 1'b1;
		end
		KIND_SUM_MAX: begin
			total = sum_acc + s;
			if (total > ACC_HI)
				total = ACC_HI;
			else if (total < ACC_LO)
				total = ACC_LO;
			sum_acc = total;
			work = total;
			eval_now = 1'b1;
		end
		KIND_INT_MIN, KIND_INT_MAX: begin
			is_min = (kind_cfg == KIND_INT_MIN);
			// A stored time of zero means no earlier sample to measure from.
			if (last_ts != 0) begin
				if (t >= last_ts) begin
					gap = t - last_ts;
					work = (gap > TICK_MAX) ? TICK_MAX : longint'(gap);
				end else begin
					gap = last_ts - t;
					work = (gap > TICK_MAX) ? -TICK_MAX : -longint'(gap);
				end
				eval_now = 1'b1;
			end
			last_ts = t;
		end
		KIND_AVG_MIN, KIND_AVG_MAX: begin
			is_min = (kind_cfg == KIND_AVG_MIN);
			span = window_span();
			slot = win_pos;
			if (slot >= span)
				slot = 0;
			// Once full, the new sample replaces the oldest one.
			if (win_count >= span)
				win_sum -= win_vals[slot];
			else
				win_count++;
			win_vals[slot] = s;
			win_sum += s;
			slot++;
			win_pos = (slot >= span) ? 0 : slot;
			if (win_count >= span) begin
				work = win_sum / longint'(span);
				eval_now = 1'b1;
			end
		end
		default: ;
		endcase

		// Open or close the violation interval on a strict crossing.
		v.begin_ts = open_since;
		v.started = 1'b0;
		v.ended = 1'b0;
		if (eval_now) begin
			if (open_since == 0) begin
				v.started = is_min ? (work < limit_cfg) : (work > limit_cfg);
				if (v.started) begin
					any_violation = 1'b1;
					open_since = t;
					v.begin_ts = t;
				end
			end else begin
				v.ended = is_min ? (work > limit_cfg) : (work < limit_cfg);
				if (v.ended)
					open_since = '0;
			end
		end
		v.evaluated = eval_now;
		v.finish_ts = t;
		v.in_viol = (open_since != 0);
		v.halted = v.started && halt_cfg;
		v.ever = any_violation;
		return v;
	endfunction

	// Random sample near a center value, with full-range values and extremes mixed in.
	function automatic logic [SAMPLE_W-1:0] pick_value(input longint center);
		longint v;
		case ($urandom_range(9))
		0: return $urandom;
		1: return SAMPLE_TOP;
		2: return SAMPLE_BOTTOM;
		default: begin
			v = center + (longint'($signed($urandom)) >>> $urandom_range(31));
			if (v > WORD_HI)
				v = WORD_HI;
			if (v < WORD_LO)
				v = WORD_LO;
			return v[SAMPLE_W-1:0];
		end
		endcase
	endfunction

	// Writes one register and mirrors it; only called while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		case (idx)
		REG_CHECK_KIND: kind_cfg = value[KIND_W-1:0];
		REG_LIMIT: limit_cfg = $signed(value);
		REG_WINDOW_LEN: begin
			// A new length restarts the window.
			wlen_cfg = value[LEN_W-1:0];
			win_sum = 0;
			win_pos = 0;
			win_count = 0;
		end
		REG_HALT: halt_cfg = value[0];
		endcase
	endtask

	// Sends one sample beat; entered and left just after a falling edge.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value,
			input logic [TIME_W-1:0] when);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		timestamp <= when;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_verdicts.insert(pending_verdicts.size(), judge_sample(value, when));
		@(negedge clk);
	endtask

	// Holds off the input until every expected result beat has come back.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
			input logic [TIME_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// Result checker: each accepted beat against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no sample waiting for it");
				error_count++;
			end else begin
				oldest = pending_verdicts.pop_front();
				compare_field("evaluated", oldest.evaluated, evaluated);
				compare_field("violation_started", oldest.started, violation_started);
				compare_field("violation_ended", oldest.ended, violation_ended);
				compare_field("interval_begin", oldest.begin_ts, interval_begin);
				compare_field("interval_finish", oldest.finish_ts, interval_finish);
				compare_field("in_violation", oldest.in_viol, in_violation);
				compare_field("halt", oldest.halted, halt);
				compare_field("ever_violated", oldest.ever, ever_violated);
			end
		end
	end

	// Plain min and max checks, strict crossings and a start at time zero.
	task automatic test_value_checks();
		write_reg(REG_HALT, 48'd1);
		write_reg(REG_CHECK_KIND, KIND_MAX);
		write_reg(REG_LIMIT, '0);
		// Flagged and halting, but no interval stays open at time zero.
		send_sample(SAMPLE_TOP, '0);
		send_sample(32'hFFFF_FFFF, 64'd5);
		send_sample(32'd1, 64'd10);
		// A value equal to the limit does not close the interval.
		send_sample(32'd0, 64'd11);
		send_sample(SAMPLE_BOTTOM, TIME_TOP);
		settle_block();
		write_reg(REG_HALT, '0);
		write_reg(REG_CHECK_KIND, KIND_MIN);
		send_sample(SAMPLE_BOTTOM, TIME_TOP);
		send_sample(32'd0, 64'd3);
		send_sample(32'd1, 64'd4);
		settle_block();
	endtask

	// Interval checks: first sample, backward time and saturated differences.
	task automatic test_interval_checks();
		write_reg(REG_CHECK_KIND, KIND_INT_MIN);
		write_reg(REG_LIMIT, 48'd10);
		send_sample($urandom, '0);
		send_sample($urandom, 64'd100);
		send_sample($urandom, 64'd105);
		send_sample($urandom, 64'd50);
		send_sample($urandom, TIME_TOP);
		settle_block();
		write_reg(REG_CHECK_KIND, KIND_INT_MAX);
		write_reg(REG_LIMIT, ACC_LO[CFG_DATA_W-1:0]);
		send_sample($urandom, '0);
		send_sample($urandom, 64'd1);
		send_sample($urandom, 64'd3);
		settle_block();
	endtask

	// Window averages, truncation toward zero, clamped length and the unused kind.
	task automatic test_window_average();
		write_reg(REG_CHECK_KIND, KIND_AVG_MAX);
		write_reg(REG_LIMIT, '0);
		write_reg(REG_WINDOW_LEN, 48'd3);
		send_sample(32'd5, 64'd1);
		send_sample(32'd5, 64'd2);
		send_sample(-32'sd20, 64'd3);
		send_sample(SAMPLE_TOP, 64'd4);
		send_sample(SAMPLE_BOTTOM, 64'd5);
		settle_block();
		write_reg(REG_WINDOW_LEN, 48'd1);
		write_reg(REG_CHECK_KIND, KIND_AVG_MIN);
		send_sample(-32'sd3, 64'd6);
		send_sample(32'd2, 64'd7);
		send_sample(-32'sd4, 64'd8);
		settle_block();
		write_reg(REG_CHECK_KIND, KIND_UNUSED);
		send_sample($urandom, 64'd9);
		settle_block();
	endtask

	// Segments of random samples, each under a fresh random configuration.
	task automatic test_random_traffic(input int item_goal);
		int sent;
		int seg_len;
		int tick_span;
		logic [KIND_W-1:0] kind;
		logic [LEN_W-1:0] wlen;
		logic [63:0] junk;
		longint lim;
		longint center;
		logic [TIME_W-1:0] ts;
		sent = 0;
		while (sent < item_goal) begin
			settle_block();
			// Unused upper data bits are sometimes filled with noise.
			junk = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
			kind = ($urandom_range(15) == 0) ? KIND_UNUSED
				: KIND_W'($urandom_range(KIND_AVG_MAX, KIND_MIN));
			write_reg(REG_CHECK_KIND, {junk[CFG_DATA_W-KIND_W-1:0], kind});

			// Limits sit near the quantity being checked so that it crosses often.
			case (kind)
			KIND_SUM_MAX: lim = sum_acc + (longint'($signed($urandom)) >>> $urandom_range(31));
			KIND_INT_MIN, KIND_INT_MAX: lim = $urandom_range(2000, 1);
			default: lim = longint'($signed($urandom)) >>> $urandom_range(31);
			endcase
			if ($urandom_range(9) == 0)
				lim = {$urandom, $urandom};
			if ($urandom_range(19) == 0)
				lim = $urandom_range(1) ? ACC_HI : ACC_LO;
			write_reg(REG_LIMIT, lim[CFG_DATA_W-1:0]);

			if (kind == KIND_AVG_MIN || kind == KIND_AVG_MAX || $urandom_range(3) == 0) begin
				case ($urandom_range(9))
				0: wlen = '0;
				1: wlen = 7'd1;
				2: wlen = LEN_W'(WINDOW_DEPTH);
				3: wlen = LEN_W'($urandom_range(127, WINDOW_DEPTH + 1));
				default: wlen = LEN_W'($urandom_range(12, 2));
				endcase
				write_reg(REG_WINDOW_LEN, {junk[CFG_DATA_W-LEN_W-1:0], wlen});
			end
			if ($urandom_range(1))
				write_reg(REG_HALT, {junk[CFG_DATA_W-2:0], 1'($urandom_range(1))});

			seg_len = $urandom_range(50, 10);
			if (kind == KIND_AVG_MIN || kind == KIND_AVG_MAX)
				seg_len += window_span();
			tick_span = (limit_cfg > 0 && limit_cfg < 100000) ? int'(limit_cfg) : 1000;
			if ($urandom_range(3) == 0)
				ts_cursor = {$urandom, $urandom};

			for (int i = 0; i < seg_len; i++) begin
				case (kind)
				KIND_INT_MIN, KIND_INT_MAX: begin
					// Mostly forward steps around the limit, with jumps back and restarts.
					case ($urandom_range(19))
					0: ts_cursor = {$urandom, $urandom};
					1: ts_cursor = ts_cursor - $urandom_range(3000);
					2: ts_cursor = '0;
					default: ts_cursor = ts_cursor + $urandom_range(2 * tick_span + 20);
					endcase
					ts = ts_cursor;
					center = 0;
				end
				KIND_SUM_MAX: begin
					ts = {$urandom, $urandom};
					center = 0;
				end
				default: begin
					ts = ($urandom_range(29) == 0) ? '0 : {$urandom, $urandom};
					center = limit_cfg;
				end
				endcase
				send_sample(pick_value(center), ts);
				sent++;
				if ($urandom_range(59) == 0)
					settle_block();
			end
		end
		settle_block();
	endtask

	// Swings the running sum with extreme samples, first up and then down.
	task automatic test_sum_extremes();
		logic [TIME_W-1:0] ts;
		settle_block();
		write_reg(REG_CHECK_KIND, KIND_SUM_MAX);
		write_reg(REG_LIMIT, '0);
		write_reg(REG_HALT, 48'd1);
		ts = 64'd1;
		repeat (20) begin
			send_sample(SAMPLE_TOP, ts);
			ts++;
		end
		repeat (40) begin
			send_sample(SAMPLE_BOTTOM, ts);
			ts++;
		end
		settle_block();
	endtask

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		timestamp = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 23;
		recv_idle_pct = 50;
		test_value_checks();
		test_interval_checks();
		test_window_average();
		test_random_traffic(420);

		send_idle_pct = 50;
		recv_idle_pct = 23;
		test_random_traffic(420);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(420);
		test_sum_extremes();

		repeat (50) @(negedge clk);
		if (error_count == 0 && pending_verdicts.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
